/* hdl/json_string_unescape_utf8_unit_macros.svh */
// Assertion macros shared by the JSON string unescaper RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define JSU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define JSU_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/jsu_pkg.sv */
// Types and codes shared by the JSON string unescaper modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  localparam int unsigned RUN_BYTES = 6;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE     = 3'd1;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd2;
  localparam logic [2:0] ERR_ESC_UNTERM   = 3'd3;
  localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd4;
  localparam logic [2:0] ERR_UNI_TRUNC    = 3'd5;
  localparam logic [2:0] ERR_NON_HEX      = 3'd6;

  // What follows the data bytes of one run.
  typedef enum logic [1:0] {
    TAIL_NONE  = 2'd0,
    TAIL_CLOSE = 2'd1,
    TAIL_ERROR = 2'd2
  } tail_e;

  // All results caused by one request: data bytes, then an optional tail.
  typedef struct packed {
    logic [RUN_BYTES-1:0][7:0] bytes;
    logic [2:0]                ndata;
    tail_e                     tail;
    logic [2:0]                code;
  } run_t;

endpackage

`default_nettype wire

/* hdl/jsu_front.sv */
// Front end of the JSON string unescaper: parses one request per cycle
// while the run queue has room into a run descriptor. Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        end_of_text_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output jsu_pkg::run_t    run_o
);
  import jsu_pkg::*;

  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_STR    = 11'b000_0000_0010,
    PH_ESC    = 11'b000_0000_0100,
    PH_HEX    = 11'b000_0000_1000,
    PH_HEXBAD = 11'b000_0001_0000,
    PH_HIGH   = 11'b000_0010_0000,
    PH_HIGHBS = 11'b000_0100_0000,
    PH_LOW    = 11'b000_1000_0000,
    PH_LOWBAD = 11'b001_0000_0000,
    PH_DONE   = 11'b010_0000_0000,
    PH_FAIL   = 11'b100_0000_0000
  } phase_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [2:0][7:0] b;
  } enc_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  // UTF-8 encoding of a code point in the basic plane.
  function automatic enc_t enc16(input logic [15:0] v);
    enc_t e;
    e = '0;
    if (v <= 16'h007f) begin
      e.len  = 3'd1;
      e.b[0] = {1'b0, v[6:0]};
    end else if (v <= 16'h07ff) begin
      e.len  = 3'd2;
      e.b[0] = {3'b110, v[10:6]};
      e.b[1] = {2'b10, v[5:0]};
    end else begin
      e.len  = 3'd3;
      e.b[0] = {4'b1110, v[15:12]};
      e.b[1] = {2'b10, v[11:6]};
      e.b[2] = {2'b10, v[5:0]};
    end
    return e;
  endfunction

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] hi_q, hi_d;

  logic            accept;
  hex_t            hd;
  logic [15:0]     acc_n;
  logic            bad;
  logic            low_ph;
  logic            str_step, esc_step, val_step, pair_step, emit_hi;
  logic            do_fail;
  logic [2:0]      fail_code;
  tail_e           tail;
  logic [2:0]      m_len;
  logic [3:0][7:0] m_bytes;
  enc_t            enc_v, enc_hi;
  logic [20:0]     cp_pair;
  logic [2:0]      nd;
  logic [RUN_BYTES-1:0][7:0] db;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  assign hd      = hex_digit(in_byte_i);
  assign acc_n   = hd.ok ? {acc_q[11:0], hd.val} : acc_q;
  assign low_ph  = (phase_q == PH_LOW) || (phase_q == PH_LOWBAD);
  assign bad     = (phase_q == PH_HEXBAD) || (phase_q == PH_LOWBAD) || !hd.ok;
  assign enc_v   = enc16(acc_n);
  assign enc_hi  = enc16(hi_q);
  assign cp_pair = 21'h010000 + {1'b0, hi_q[9:0], acc_n[9:0]};

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    hi_d      = hi_q;
    str_step  = 1'b0;
    esc_step  = 1'b0;
    val_step  = 1'b0;
    pair_step = 1'b0;
    emit_hi   = 1'b0;
    do_fail   = 1'b0;
    fail_code = ERR_NONE;
    tail      = TAIL_NONE;
    m_len     = 3'd0;
    m_bytes   = '0;

    unique case (phase_q)
      PH_IDLE: begin
        if (in_byte_i == CH_QUOTE) begin
          phase_d = PH_STR;
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_NO_QUOTE;
        end
      end
      PH_STR: str_step = 1'b1;
      PH_ESC: esc_step = 1'b1;
      PH_HIGH: begin
        if (in_byte_i == CH_BSL) begin
          phase_d = PH_HIGHBS;
        end else begin
          emit_hi  = 1'b1;
          str_step = 1'b1;
        end
      end
      PH_HIGHBS: begin
        if (in_byte_i == CH_U) begin
          phase_d = PH_LOW;
          acc_d   = '0;
          cnt_d   = '0;
        end else begin
          emit_hi  = 1'b1;
          esc_step = 1'b1;
        end
      end
      PH_HEX, PH_HEXBAD, PH_LOW, PH_LOWBAD: begin
        if (cnt_q == 2'd3) begin
          acc_d = '0;
          cnt_d = '0;
          if (bad) begin
            do_fail   = 1'b1;
            fail_code = ERR_NON_HEX;
          end else if (low_ph && acc_n >= 16'hdc00 && acc_n <= 16'hdfff) begin
            pair_step = 1'b1;
          end else begin
            // A second escape that is no low surrogate releases the held one.
            emit_hi  = low_ph;
            val_step = 1'b1;
          end
        end else begin
          acc_d = acc_n;
          cnt_d = cnt_q + 2'd1;
          if (low_ph) begin
            phase_d = bad ? PH_LOWBAD : PH_LOW;
          end else begin
            phase_d = bad ? PH_HEXBAD : PH_HEX;
          end
        end
      end
      default: ;
    endcase

    if (str_step) begin
      if (in_byte_i == CH_QUOTE) begin
        tail    = TAIL_CLOSE;
        phase_d = PH_DONE;
      end else if (in_byte_i == CH_BSL) begin
        phase_d = PH_ESC;
      end else begin
        m_len      = 3'd1;
        m_bytes[0] = in_byte_i;
        phase_d    = PH_STR;
      end
    end

    if (esc_step) begin
      phase_d = PH_STR;
      m_len   = 3'd1;
      unique case (in_byte_i)
        CH_QUOTE: m_bytes[0] = CH_QUOTE;
        CH_BSL:   m_bytes[0] = CH_BSL;
        CH_SLASH: m_bytes[0] = CH_SLASH;
        CH_B:     m_bytes[0] = 8'h08;
        CH_F:     m_bytes[0] = 8'h0c;
        CH_N:     m_bytes[0] = 8'h0a;
        CH_R:     m_bytes[0] = 8'h0d;
        CH_T:     m_bytes[0] = 8'h09;
        CH_U: begin
          m_len   = 3'd0;
          phase_d = PH_HEX;
          acc_d   = '0;
          cnt_d   = '0;
        end
        default: begin
          m_len     = 3'd0;
          do_fail   = 1'b1;
          fail_code = ERR_BAD_ESCAPE;
        end
      endcase
    end

    if (val_step) begin
      if (acc_n >= 16'hd800 && acc_n <= 16'hdbff) begin
        hi_d    = acc_n;
        phase_d = PH_HIGH;
      end else begin
        m_len        = enc_v.len;
        m_bytes[2:0] = enc_v.b;
        phase_d      = PH_STR;
      end
    end

    if (pair_step) begin
      m_len      = 3'd4;
      m_bytes[0] = {5'b11110, cp_pair[20:18]};
      m_bytes[1] = {2'b10, cp_pair[17:12]};
      m_bytes[2] = {2'b10, cp_pair[11:6]};
      m_bytes[3] = {2'b10, cp_pair[5:0]};
      phase_d    = PH_STR;
    end

    if (do_fail) begin
      phase_d = PH_FAIL;
    end

    if (end_of_text_i) begin
      unique case (phase_d)
        PH_STR, PH_HIGH: begin
          do_fail   = 1'b1;
          fail_code = ERR_UNTERMINATED;
        end
        PH_ESC, PH_HIGHBS: begin
          do_fail   = 1'b1;
          fail_code = ERR_ESC_UNTERM;
        end
        PH_HEX, PH_HEXBAD, PH_LOW, PH_LOWBAD: begin
          do_fail   = 1'b1;
          fail_code = ERR_UNI_TRUNC;
        end
        default: ;
      endcase
      phase_d = PH_IDLE;
      acc_d   = '0;
      cnt_d   = '0;
      hi_d    = '0;
    end
  end

  // Pack the released high surrogate ahead of the bytes of this request.
  always_comb begin
    db = '0;
    if (emit_hi) begin
      db[2:0] = enc_hi.b;
      db[5:3] = m_bytes[2:0];
      nd      = 3'd3 + m_len;
    end else begin
      db[3:0] = m_bytes;
      nd      = m_len;
    end
    run_o.bytes = db;
    run_o.ndata = do_fail ? 3'd0 : nd;
    run_o.tail  = do_fail ? TAIL_ERROR : tail;
    run_o.code  = do_fail ? fail_code : ERR_NONE;
  end

  assign push_o = accept && (do_fail || nd != 3'd0 || tail != TAIL_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
      hi_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      hi_q    <= hi_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/jsu_queue.sv */
// Run descriptor queue between the parser and the result serialiser.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  jsu_pkg::run_t data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output jsu_pkg::run_t data_o
);
  import jsu_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  run_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wrap_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= wrap_inc(rd_q);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/jsu_back.sv */
// Back end of the JSON string unescaper: plays out one run descriptor as
// single results on the output channel. Depends on jsu_pkg and the macros.
`timescale 1ns / 1ps
`default_nettype none

`include "json_string_unescape_utf8_unit_macros.svh"

module jsu_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  jsu_pkg::run_t    q_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       kind_o,
  output logic [2:0]       error_code_o,
  output logic             last_of_run_o
);
  import jsu_pkg::*;

  run_t       cur_q;
  logic [2:0] idx_q;
  logic       busy_q;

  logic [2:0] total;
  logic       data_sel;
  logic       out_acc;

  assign total    = cur_q.ndata + {2'b00, (cur_q.tail != TAIL_NONE)};
  assign data_sel = (idx_q < cur_q.ndata);
  assign out_acc  = busy_q && !out_stall_i;

  assign out_valid_o   = busy_q;
  assign last_of_run_o = (idx_q == total - 3'd1);
  assign out_byte_o    = data_sel ? cur_q.bytes[idx_q] : 8'h00;
  assign error_code_o  = data_sel ? ERR_NONE : cur_q.code;

  always_comb begin
    if (data_sel) begin
      kind_o = KIND_DATA;
    end else if (cur_q.tail == TAIL_ERROR) begin
      kind_o = KIND_ERROR;
    end else begin
      kind_o = KIND_CLOSE;
    end
  end

  // The next run is taken in the cycle in which the last result of the
  // current one leaves, so runs follow without a gap.
  assign pop_o = q_valid_i && (!busy_q || (out_acc && last_of_run_o));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (out_acc) begin
      if (last_of_run_o) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  `JSU_ASSERT(a_tail_is_last, clk_i, rst_ni, (out_valid_o && kind_o != KIND_DATA) |-> last_of_run_o, "close or error result is not the last of its run")
  `JSU_NEVER(a_tail_byte_zero, clk_i, rst_ni, out_valid_o && kind_o != KIND_DATA && out_byte_o != 8'h00, "non-data result carries a byte")
  `JSU_NEVER(a_code_only_on_error, clk_i, rst_ni, out_valid_o && kind_o != KIND_ERROR && error_code_o != ERR_NONE, "error code outside an error result")
  `JSU_ASSERT(a_run_continues, clk_i, rst_ni, (out_valid_o && !out_stall_i && !last_of_run_o) |=> out_valid_o, "run broke off before its last result")

endmodule

`default_nettype wire

/* hdl/json_string_unescape_utf8_unit.sv */
// Top level of the JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i / in_stall_o  in_byte_i, end_of_text_i
//  out      output     out_valid_o/out_stall_i  out_byte_o, kind_o, error_code_o,
//                                               last_of_run_o
//
// A request is taken every cycle while the run queue has room; the parser
// turns any byte into its run descriptor combinationally. The serialiser gives
// one result per cycle while the output is not stalled, and the results of
// a request leave one after another. With the serialiser idle, the first result
// of a request passes the queue entry and the serialiser's run register first.
// Reset clears the parser, queue pointers and serialiser at once; no sweep.
// An output stall backs up through the QUEUE_DEPTH-entry queue to in_stall_o.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_text_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      kind_o,
  output logic [2:0]      error_code_o,
  output logic            last_of_run_o
);
  import jsu_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  run_t run_in, run_out;

  jsu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .run_o         (run_in)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (run_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (run_out)
  );

  jsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (run_out),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .error_code_o  (error_code_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

/* sim/jsu_unescape_checker.sv */
`timescale 1ns / 1ps
// Checker for the JSON string unescaper: watches both channels and predicts results.
// Depends on jsu_pkg for the kind and error codes and the largest run.

module jsu_unescape_checker
  import jsu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_text_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_byte_i,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  error_code_i,
  input  logic        last_of_run_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_STR, PH_ESC, PH_HEX, PH_HEXBAD, PH_HIGH, PH_HIGHBS,
    PH_LOW, PH_LOWBAD, PH_DONE, PH_FAIL
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] code;
    logic       last;
  } result_t;

  phase_e      phase;
  logic [15:0] hex_acc;
  logic [1:0]  hex_cnt;
  logic [15:0] held_high;

  result_t     run_q[$];
  result_t     want_q[$];
  int unsigned fails;

  task automatic clear_parser();
    phase      = PH_IDLE;
    hex_acc    = '0;
    hex_cnt    = '0;
    held_high  = '0;
  endtask

  task automatic add_result(input logic [7:0] b, input logic [1:0] k, input logic [2:0] c);
    result_t r;
    if (run_q.size() < RUN_BYTES) begin
      r.data = b;
      r.kind = k;
      r.code = c;
      r.last = 1'b0;
      run_q.insert(run_q.size(), r);
    end
  endtask

  // An error discards whatever the request produced so far.
  task automatic abort_text(input logic [2:0] c);
    run_q.delete();
    add_result(8'h00, KIND_ERROR, c);
    phase = PH_FAIL;
  endtask

  task automatic add_code_point(input logic [20:0] cp);
    if (cp <= 21'h7f) begin
      add_result(cp[7:0], KIND_DATA, ERR_NONE);
    end else if (cp <= 21'h7ff) begin
      add_result(8'hc0 | {3'd0, cp[10:6]}, KIND_DATA, ERR_NONE);
      add_result(8'h80 | {2'd0, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else if (cp <= 21'hffff) begin
      add_result(8'he0 | {4'd0, cp[15:12]}, KIND_DATA, ERR_NONE);
      add_result(8'h80 | {2'd0, cp[11:6]}, KIND_DATA, ERR_NONE);
      add_result(8'h80 | {2'd0, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else begin
      add_result(8'hf0 | {5'd0, cp[20:18]}, KIND_DATA, ERR_NONE);
      add_result(8'h80 | {2'd0, cp[17:12]}, KIND_DATA, ERR_NONE);
      add_result(8'h80 | {2'd0, cp[11:6]}, KIND_DATA, ERR_NONE);
      add_result(8'h80 | {2'd0, cp[5:0]}, KIND_DATA, ERR_NONE);
    end
  endtask

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  task automatic string_byte(input logic [7:0] c);
    if (c == "\"") begin
      add_result(8'h00, KIND_CLOSE, ERR_NONE);
      phase = PH_DONE;
    end else if (c == "\\") begin
      phase = PH_ESC;
    end else begin
      add_result(c, KIND_DATA, ERR_NONE);
      phase = PH_STR;
    end
  endtask

  task automatic escape_byte(input logic [7:0] c);
    logic [7:0] b;
    logic       simple;
    simple = 1'b1;
    b      = c;
    case (c)
      "\"", "\\", "/": b = c;
      "b": b = 8'h08;
      "f": b = 8'h0c;
      "n": b = 8'h0a;
      "r": b = 8'h0d;
      "t": b = 8'h09;
      "u": begin
        simple  = 1'b0;
        phase   = PH_HEX;
        hex_acc = '0;
        hex_cnt = '0;
      end
      default: begin
        simple = 1'b0;
        abort_text(ERR_BAD_ESCAPE);
      end
    endcase
    if (simple) begin
      add_result(b, KIND_DATA, ERR_NONE);
      phase = PH_STR;
    end
  endtask

  task automatic take_value(input logic [15:0] v);
    if (v >= 16'hd800 && v <= 16'hdbff) begin
      held_high  = v;
      phase      = PH_HIGH;
    end else begin
      add_code_point({5'd0, v});
      phase = PH_STR;
    end
  endtask

  task automatic take_low(input logic [15:0] v);
    logic [15:0] hi;
    hi         = held_high;
    if (v >= 16'hdc00 && v <= 16'hdfff && hi >= 16'hd800 && hi <= 16'hdbff) begin
      add_code_point(21'h10000 + ({11'd0, hi[9:0]} << 10) + {11'd0, v[9:0]});
      phase = PH_STR;
    end else begin
      // The held surrogate goes out alone and the new value starts afresh.
      add_code_point({5'd0, hi});
      take_value(v);
    end
  endtask

  task automatic hex_byte(input logic [7:0] c, input logic low);
    int          d;
    logic        bad;
    logic [15:0] acc;
    d   = hex_digit(c);
    bad = (phase == PH_HEXBAD) || (phase == PH_LOWBAD) || (d < 0);
    acc = hex_acc;
    if (d >= 0) acc = {acc[11:0], 4'(d)};
    if (hex_cnt == 2'd3) begin
      hex_cnt = '0;
      hex_acc = '0;
      if (bad) abort_text(ERR_NON_HEX);
      else if (low) take_low(acc);
      else take_value(acc);
    end else begin
      hex_acc = acc;
      hex_cnt = hex_cnt + 2'd1;
      if (low) phase = bad ? PH_LOWBAD : PH_LOW;
      else phase = bad ? PH_HEXBAD : PH_HEX;
    end
  endtask

  task automatic predict_request(input logic [7:0] c, input logic eot);
    run_q.delete();
    case (phase)
      PH_IDLE: begin
        if (c == "\"") phase = PH_STR;
        else abort_text(ERR_NO_QUOTE);
      end
      PH_STR: string_byte(c);
      PH_ESC: escape_byte(c);
      PH_HEX, PH_HEXBAD: hex_byte(c, 1'b0);
      PH_LOW, PH_LOWBAD: hex_byte(c, 1'b1);
      PH_HIGH: begin
        if (c == "\\") begin
          phase = PH_HIGHBS;
        end else begin
          add_code_point({5'd0, held_high});
          string_byte(c);
        end
      end
      PH_HIGHBS: begin
        if (c == "u") begin
          phase   = PH_LOW;
          hex_acc = '0;
          hex_cnt = '0;
        end else begin
          add_code_point({5'd0, held_high});
          escape_byte(c);
        end
      end
      default: ;
    endcase
    if (eot) begin
      case (phase)
        PH_STR, PH_HIGH: abort_text(ERR_UNTERMINATED);
        PH_ESC, PH_HIGHBS: abort_text(ERR_ESC_UNTERM);
        PH_HEX, PH_HEXBAD, PH_LOW, PH_LOWBAD: abort_text(ERR_UNI_TRUNC);
        default: ;
      endcase
      clear_parser();
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
    foreach (run_q[i]) want_q.insert(want_q.size(), run_q[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      clear_parser();
      want_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.data = out_byte_i;
        got.kind = kind_i;
        got.code = error_code_i;
        got.last = last_of_run_i;
        if (want_q.size() == 0) begin
          if (fails < 10)
            $display("unexpected result: byte %02h kind %0d code %0d last %0d",
                     got.data, got.kind, got.code, got.last);
          fails++;
        end else begin
          want = want_q.pop_front();
          if (got != want) begin
            if (fails < 10)
              $display({"mismatch: expected byte %02h kind %0d code %0d last %0d,",
                        " got byte %02h kind %0d code %0d last %0d"},
                       want.data, want.kind, want.code, want.last,
                       got.data, got.kind, got.code, got.last);
            fails++;
          end
        end
      end
      // Results of a request taken at this edge cannot appear before the next one.
      if (in_valid_i && !in_stall_i) predict_request(in_byte_i, end_of_text_i);
    end
    fail_count_o = fails;
    pending_o    = want_q.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the JSON string unescaper: drives texts and gives the verdict.
// Depends on jsu_pkg, json_string_unescape_utf8_unit and jsu_unescape_checker.

module tb;
  import jsu_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned RANDOM_BYTES = 270;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        end_of_text_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic [1:0]  kind_o;
  logic [2:0]  error_code_o;
  logic        last_of_run_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt;
  int unsigned bytes_sent;
  int          burst_left;
  logic [7:0]  text_q[$];

  json_string_unescape_utf8_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .end_of_text_i(end_of_text_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .error_code_o (error_code_o),
    .last_of_run_o(last_of_run_o)
  );

  jsu_unescape_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .end_of_text_i(end_of_text_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_i   (out_byte_o),
    .kind_i       (kind_o),
    .error_code_i (error_code_o),
    .last_of_run_i(last_of_run_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i) cycle_cnt++;
    $display("[json_string_unescape_utf8_unit] ERROR");
    $finish;
  end

  // The receiver switches between free running, light, even and heavy stalling.
  initial begin
    int mode;
    int len;
    out_stall_i = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 80);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        in_byte_i  <= 8'($urandom_range(0, 255));
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Holds the sender off until every request has been answered.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic add_text_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) add_text_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic upper;
    upper = 1'($urandom_range(0, 1));
    if (nib < 10) return 8'h30 + {4'd0, nib};
    return (upper ? 8'h41 : 8'h61) + {4'd0, nib - 4'd10};
  endfunction

  // A \u escape, now and then with one digit that is not hex.
  task automatic push_escape_u(input logic [15:0] v);
    int bad_pos;
    bad_pos = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 3) : -1;
    add_text_byte("\\");
    add_text_byte("u");
    for (int i = 3; i >= 0; i--) begin
      if (i == bad_pos) add_text_byte(8'h67 + 8'($urandom_range(0, 19)));
      else add_text_byte(hex_char(v[i*4 +: 4]));
    end
  endtask

  task automatic push_segment();
    string      esc_set;
    logic [7:0] c;
    esc_set = "\"\\/bfnrt";
    case ($urandom_range(0, 11))
      0, 1, 2, 3: begin
        c = 8'($urandom_range(0, 255));
        if (c == "\"" || c == "\\") c = $urandom_range(0, 1) ? 8'h00 : 8'hff;
        add_text_byte(c);
      end
      4, 5: begin
        add_text_byte("\\");
        add_text_byte(esc_set[$urandom_range(0, 7)]);
      end
      6: push_escape_u(16'($urandom_range(0, 16'h07ff)));
      7: push_escape_u(16'($urandom_range(0, 16'hffff)));
      8: begin
        push_escape_u(16'($urandom_range(16'hd800, 16'hdbff)));
        push_escape_u(16'($urandom_range(16'hdc00, 16'hdfff)));
      end
      9: begin
        // A high surrogate left alone, before a byte, a simple escape or a non-low value.
        push_escape_u(16'($urandom_range(16'hd800, 16'hdbff)));
        case ($urandom_range(0, 2))
          0: add_text_byte(8'("a" + $urandom_range(0, 25)));
          1: begin
            add_text_byte("\\");
            add_text_byte(esc_set[$urandom_range(0, 7)]);
          end
          default: push_escape_u(16'($urandom_range(0, 1) ? $urandom_range(16'hd800, 16'hdbff)
                                                          : $urandom_range(0, 16'hd7ff)));
        endcase
      end
      10: push_escape_u(16'($urandom_range(0, 1) ? $urandom_range(16'hdc00, 16'hdfff)
                                                 : ($urandom_range(0, 1) ? 0 : 16'hffff)));
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          c = 8'($urandom_range(0, 255));
          for (int i = 0; i < 8; i++) if (c == esc_set[i]) c = "q";
          if (c == "u") c = "q";
          add_text_byte("\\");
          add_text_byte(c);
        end else begin
          add_text_byte(8'("a" + $urandom_range(0, 25)));
        end
      end
    endcase
  endtask

  task automatic build_random_text();
    int shape;
    int nseg;
    int cut;
    shape = $urandom_range(0, 99);
    if (shape < 8) begin
      repeat ($urandom_range(1, 6)) add_text_byte(8'($urandom_range(0, 255)));
    end else begin
      add_text_byte("\"");
      nseg = $urandom_range(0, 7);
      repeat (nseg) push_segment();
      if (shape < 80) begin
        add_text_byte("\"");
        repeat ($urandom_range(0, 2)) add_text_byte(8'($urandom_range(0, 255)));
      end else begin
        // The text stops early, wherever the cut lands.
        cut = $urandom_range(1, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_byte_i     = 8'h00;
    end_of_text_i = 1'b0;
    bytes_sent    = 0;
    burst_left    = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // A surrogate pair, then a byte after the close.
    push_str("\"\\uD83D\\uDE00\"");
    add_text_byte(8'hff);
    send_text();
    // No opening quote.
    add_text_byte(8'hff);
    send_text();
    // An unknown escape, then an ignored byte.
    push_str("\"\\qz");
    send_text();
    // Text ending inside a \u escape.
    push_str("\"\\u12");
    send_text();
    drain();

    while (bytes_sent < RANDOM_BYTES) begin
      build_random_text();
      send_text();
      if ($urandom_range(0, 15) == 0) drain();
    end

    drain();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[json_string_unescape_utf8_unit] OK");
    end else begin
      $display("[json_string_unescape_utf8_unit] ERROR");
    end
    $finish;
  end

endmodule
